// ----- rtl/sbda_pkg.sv -----
// Shared constants and power-of-ten table for the signed binary to decimal ASCII core.
package sbda_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGITS_MAX     = 20;
	localparam int IDX_W          = $clog2(DIGITS_MAX);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef logic [IDX_W-1:0] idx_t;

	// Powers of ten, largest first.
	function automatic logic [63:0] pow10(input idx_t i);
		logic [63:0] p;
		unique case (i)
			5'd0:    p = 64'd10000000000000000000;
			5'd1:    p = 64'd1000000000000000000;
			5'd2:    p = 64'd100000000000000000;
			5'd3:    p = 64'd10000000000000000;
			5'd4:    p = 64'd1000000000000000;
			5'd5:    p = 64'd100000000000000;
			5'd6:    p = 64'd10000000000000;
			5'd7:    p = 64'd1000000000000;
			5'd8:    p = 64'd100000000000;
			5'd9:    p = 64'd10000000000;
			5'd10:   p = 64'd1000000000;
			5'd11:   p = 64'd100000000;
			5'd12:   p = 64'd10000000;
			5'd13:   p = 64'd1000000;
			5'd14:   p = 64'd100000;
			5'd15:   p = 64'd10000;
			5'd16:   p = 64'd1000;
			5'd17:   p = 64'd100;
			5'd18:   p = 64'd10;
			5'd19:   p = 64'd1;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	// First table entry that can be reached by a magnitude of vb bits (max 2^(vb-1)).
	function automatic int start_index(input int vb);
		logic [63:0] max_mag;
		int          s;
		max_mag = 64'd1 << (vb - 1);
		s = 0;
		for (int i = 0; i < DIGITS_MAX; i++) begin
			if (pow10(idx_t'(i)) > max_mag) begin
				s = i + 1;
			end
		end
		return s;
	endfunction

endpackage

// ----- rtl/signed_binary_to_decimal_ascii_core.sv -----
// Top level: signed binary to decimal ASCII converter, one character per output beat.
// Sequence: an accept, a '-' beat for negative values, a scan over the leading powers of ten
//   that are skipped, then for each digit four trial subtractions and an emit beat.
// Throughput: one number at a time; src_stall is high from accept until the last beat
//   is loaded into the output register. Set by the single shared compare/subtract unit.
// Reset: arst_n clears the sequencer and output valid; payload registers are not reset.
module signed_binary_to_decimal_ascii_core #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic signed [VALUE_BITS-1:0]  value,
	// output channel, one beat per character
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output logic [7:0]                    character,
	output logic                          last
);
	import sbda_pkg::*;

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SIGN  = 3'd1;  // emit '-'
	localparam logic [2:0] ST_SCAN  = 3'd2;  // skip leading zero digits
	localparam logic [2:0] ST_DIGIT = 3'd3;  // trial subtract 8,4,2,1 x pow
	localparam logic [2:0] ST_EMIT  = 3'd4;  // send finished digit

	localparam idx_t START_IDX = idx_t'(start_index(VALUE_BITS));
	localparam idx_t LAST_IDX  = idx_t'(DIGITS_MAX - 1);

	logic [2:0]            state_q;
	idx_t                  idx_q;
	logic [1:0]            step_q;
	logic [3:0]            digit_q;
	logic [VALUE_BITS-1:0] mag_q;

	logic                  dst_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	// Shared unit hookup
	logic [VALUE_BITS-1:0] pow_w;
	logic [1:0]            unit_step;
	logic                  fits;
	logic [VALUE_BITS-1:0] rem;

	// Output load control
	logic                  out_free;
	logic                  load_out;
	logic [7:0]            load_char;
	logic                  load_last;

	logic                  neg;
	logic [VALUE_BITS-1:0] abs_val;

	// Magnitude as unsigned: most negative value maps to 2^(VALUE_BITS-1) with no wrap.
	assign neg     = value[VALUE_BITS-1];
	assign abs_val = neg ? (~value + 1'b1) : value;

	// Every table entry at or after START_IDX fits in VALUE_BITS bits.
	assign pow_w     = VALUE_BITS'(pow10(idx_q));
	// Scan is a plain mag >= pow test, i.e. step 0.
	assign unit_step = (state_q == ST_DIGIT) ? step_q : 2'd0;

	sbda_sub_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_sub (
		.mag  (mag_q),
		.pow  (pow_w),
		.step (unit_step),
		.fits (fits),
		.rem  (rem)
	);

	// Output register is free when empty or being drained this cycle.
	assign out_free = !dst_valid_q || !dst_stall;

	always_comb begin
		load_out  = 1'b0;
		load_char = CHAR_ZERO;
		load_last = 1'b0;
		unique case (state_q)
			ST_SIGN: begin
				load_out  = out_free;
				load_char = CHAR_MINUS;
			end
			ST_SCAN: begin
				// value zero: single '0'
				load_out  = out_free && !fits && (idx_q == LAST_IDX);
				load_char = CHAR_ZERO;
				load_last = 1'b1;
			end
			ST_EMIT: begin
				load_out  = out_free;
				load_char = CHAR_ZERO + {4'd0, digit_q};
				load_last = (idx_q == LAST_IDX);
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= START_IDX;
			step_q      <= 2'd0;
			digit_q     <= 4'd0;
			dst_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						idx_q   <= START_IDX;
						step_q  <= 2'd0;
						digit_q <= 4'd0;
						state_q <= neg ? ST_SIGN : ST_SCAN;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fits) begin
						step_q  <= 2'd3;
						digit_q <= 4'd0;
						state_q <= ST_DIGIT;
					end else if (idx_q == LAST_IDX) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIGIT: begin
					if (fits) begin
						digit_q[step_q] <= 1'b1;
					end
					if (step_q == 2'd0) begin
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							step_q  <= 2'd3;
							digit_q <= 4'd0;
							state_q <= ST_DIGIT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Remainder and output payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && src_valid) begin
			mag_q <= abs_val;
		end else if (state_q == ST_DIGIT && fits) begin
			mag_q <= rem;
		end
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = dst_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ----- rtl/sbda_sub_unit.sv -----
// Shared compare/subtract unit: tests remainder against a scaled power of ten.
module sbda_sub_unit #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic [VALUE_BITS-1:0] mag,
	input  logic [VALUE_BITS-1:0] pow,
	input  logic [1:0]            step,
	output logic                  fits,
	output logic [VALUE_BITS-1:0] rem
);
	import sbda_pkg::*;

	// Shifting mag down avoids overflow of pow << step in the compare.
	assign fits = (mag >> step) >= pow;
	assign rem  = mag - (pow << step);

endmodule
